// ----- sv/hti_pkg.sv -----
// Shared constants for the triangulated heightmap interpolator.
// No dependencies; imported by the grid bank, the top level and the testbench.
package hti_pkg;

  // Grid geometry
  localparam int TILES_PER_SQ   = 16;
  localparam int UNITS_PER_TILE = 64;
  localparam int UPT_LOG2       = $clog2(UNITS_PER_TILE);
  localparam int PAD_TILES      = 16;
  localparam int GRID_DIM_DEF   = 256;

  // Height format: stored entry is eight times the raw byte
  localparam int HS_LOG2    = 3;
  localparam int H_W        = 11;
  localparam int HEIGHT_MAX = 2040;

  // Field widths
  localparam int P_W   = 16;
  localparam int SQ_W  = 4;
  localparam int BYTE_W = 8;

  // Bank address width for the default grid (four banks by row/column parity)
  localparam int BANK_AW_DEF = 2 * $clog2((GRID_DIM_DEF + 1) / 2);

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] CFG_SQ_ROWS = 1'b0;
  localparam logic [0:0] CFG_SQ_COLS = 1'b1;

  localparam logic [SQ_W-1:0] SQ_RESET = 4'd6;

endpackage

// ----- sv/hti_bank.sv -----
// One parity bank of the height grid: single write port, single registered read port.
// Depends on hti_pkg for the default entry width.
module hti_bank import hti_pkg::*; #(
  parameter int AW = BANK_AW_DEF,
  parameter int DW = H_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data while the consuming stage is stalled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/heightmap_triangle_interpolator_top.sv -----
// Top level of the triangulated heightmap interpolator: input decode, banked grid, arithmetic.
// Depends on hti_pkg and instantiates four hti_bank grid banks.
//
// Load beats write one grid entry (8 x height byte); query beats return one interpolated
// height each, loads return nothing. The block takes one beat per clock cycle when the
// output is not stalled, and a query result passes the S1 to S5 registers in order. Each
// query needs three grid corners in the same cycle; the grid is split into four banks by
// padded row and column parity, so any 2x2 corner quad lands in four different banks and
// every bank sees one read per cycle. After reset the grid is cleared one entry per bank
// per cycle; in_ready_o stays low until the clear is done, configuration writes are taken
// as usual. Write the configuration only while no beat is in flight. Pipeline: S1 tile
// split, padding, bounds and bank addresses; S2 bank read; S3 corner selection and edge
// differences; S4 two multiplies by the remainders; S5 sum, truncating division and
// saturation (output reg).
module heightmap_triangle_interpolator_top import hti_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [SQ_W-1:0]       cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [BYTE_W-1:0]     grid_row_i,
  input  logic [BYTE_W-1:0]     grid_col_i,
  input  logic [BYTE_W-1:0]     height_byte_i,
  input  logic signed [P_W-1:0] point_row_i,
  input  logic signed [P_W-1:0] point_col_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [H_W-1:0]        height_o
);

  localparam int HALF  = (GRID_DIM + 1) / 2;
  localparam int HW    = $clog2(HALF);
  localparam int AW    = 2 * HW;
  localparam int L     = UPT_LOG2;
  localparam int R_W   = L + 1;            // signed remainder
  localparam int PI_W  = P_W - L + 2;      // signed padded index
  localparam int CMP_W = 16;               // width for bounds compares
  localparam int D_W   = H_W + 1;          // signed corner difference
  localparam int M_W   = D_W + R_W;        // product
  localparam int NUM_W = M_W + 2;          // numerator
  localparam int Q_W   = NUM_W - L;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0] sq_rows_q, sq_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_rows_q <= SQ_RESET;
      sq_cols_q <= SQ_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SQ_ROWS: sq_rows_q <= cfg_data_i;
        CFG_SQ_COLS: sq_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset: zero every bank entry, one address per cycle
  // ---------------------------------------------------------------------------
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: each stage takes a new beat when empty or when it moves on
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic query1_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, adv1, acc;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  // loads retire from S1 by writing the grid, so they never wait on later stages
  assign adv1 = v1_q && (!query1_q || rdy2);
  assign rdy1 = !v1_q || adv1;

  assign in_ready_o = rdy1 && !clr_busy_q;
  assign acc        = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // S1 input decode
  // ---------------------------------------------------------------------------
  function automatic logic idx_ok(input logic signed [PI_W-1:0] v,
                                  input logic [CMP_W-1:0] lim);
    logic [CMP_W-1:0] u;
    u = CMP_W'($unsigned(v));
    return !v[PI_W-1] && (u < lim) && (u < CMP_W'(GRID_DIM));
  endfunction

  logic signed [P_W-1:0]  pt   [2];
  logic [SQ_W-1:0]        sq   [2];
  logic signed [P_W-1:0]  flr  [2];
  logic [P_W-1:0]         tile [2];
  logic                   frac [2];
  logic [CMP_W-1:0]       lim  [2];
  logic signed [PI_W-1:0] pad  [2];
  logic signed [PI_W-1:0] pad1 [2];
  logic signed [PI_W-1:0] sel  [2][2];
  logic [HW-1:0]          half [2][2];
  logic                   selok[2][2];
  logic signed [R_W-1:0]  rem_d[2];
  logic [1:0]             par_d;
  logic [AW-1:0]          raddr_d [4];
  logic [3:0]             bok_d;

  assign pt[0] = point_row_i;
  assign pt[1] = point_col_i;
  assign sq[0] = sq_rows_q;
  assign sq[1] = sq_cols_q;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      // truncating split: floor, then step up when negative with a remainder
      frac[a]  = pt[a][P_W-1] && (pt[a][L-1:0] != '0);
      flr[a]   = pt[a] >>> L;
      tile[a]  = flr[a] + P_W'(frac[a]);
      pad[a]   = PI_W'(tile[a] + P_W'(PAD_TILES));
      pad1[a]  = pad[a] + PI_W'(1);
      rem_d[a] = {frac[a], pt[a][L-1:0]};
      par_d[a] = pad[a][0];
      lim[a]   = CMP_W'(sq[a]) * CMP_W'(TILES_PER_SQ) + CMP_W'(2 * PAD_TILES + 1);
      for (int e = 0; e < 2; e++) begin
        sel[a][e]   = (pad[a][0] == 1'(e)) ? pad[a] : pad1[a];
        half[a][e]  = sel[a][e][HW:1];
        selok[a][e] = idx_ok(sel[a][e], lim[a]);
      end
    end
    for (int b = 0; b < 4; b++) begin
      raddr_d[b] = {half[0][b >> 1], half[1][b & 1]};
      bok_d[b]   = selok[0][b >> 1] && selok[1][b & 1];
    end
  end

  // load decode
  logic [CMP_W-1:0] lrow, lcol;
  logic             wok_d;
  logic [AW-1:0]    waddr_d;
  logic [H_W-1:0]   wdata_d;

  assign lrow    = CMP_W'(grid_row_i);
  assign lcol    = CMP_W'(grid_col_i);
  assign wok_d   = (lrow < CMP_W'(GRID_DIM)) && (lcol < CMP_W'(GRID_DIM));
  assign waddr_d = {lrow[HW:1], lcol[HW:1]};
  assign wdata_d = H_W'({height_byte_i, {HS_LOG2{1'b0}}});

  logic                  wok1_q;
  logic [1:0]            wbank1_q;
  logic [AW-1:0]         waddr1_q;
  logic [H_W-1:0]        wdata1_q;
  logic [AW-1:0]         raddr1_q [4];
  logic [3:0]            bok1_q;
  logic [1:0]            par1_q;
  logic signed [R_W-1:0] rem1_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      query1_q <= (req_type_i == REQ_QUERY);
      wok1_q   <= wok_d;
      wbank1_q <= {grid_row_i[0], grid_col_i[0]};
      waddr1_q <= waddr_d;
      wdata1_q <= wdata_d;
      raddr1_q <= raddr_d;
      bok1_q   <= bok_d;
      par1_q   <= par_d;
      rem1_q   <= rem_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Grid banks (S2 read data registered inside each bank)
  // ---------------------------------------------------------------------------
  logic           rd_en;
  logic [AW-1:0]  bank_waddr;
  logic [H_W-1:0] bank_wdata;
  logic [3:0]     bank_we;
  logic [H_W-1:0] bank_rdata [4];

  assign rd_en      = v1_q && query1_q && rdy2;
  assign bank_waddr = clr_busy_q ? clr_cnt_q : waddr1_q;
  assign bank_wdata = clr_busy_q ? '0 : wdata1_q;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign bank_we[b] = clr_busy_q ||
                        (v1_q && !query1_q && wok1_q && (wbank1_q == 2'(b)));

    hti_bank #(
      .AW (AW),
      .DW (H_W)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr),
      .wdata_i (bank_wdata),
      .re_i    (rd_en),
      .raddr_i (raddr1_q[b]),
      .rdata_o (bank_rdata[b])
    );
  end

  logic [3:0]            bok2_q;
  logic [1:0]            par2_q;
  logic signed [R_W-1:0] rem2_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q && query1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      bok2_q <= bok1_q;
      par2_q <= par1_q;
      rem2_q <= rem1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // S3: mask out-of-grid corners, pick the triangle, form edge differences
  // ---------------------------------------------------------------------------
  logic [H_W-1:0]        dat [4];
  logic [H_W-1:0]        c00, c01, c10, c11, mid;
  logic                  upper;
  logic signed [D_W-1:0] coef_r_d, coef_c_d;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      dat[b] = bok2_q[b] ? bank_rdata[b] : '0;
    end
    // corner (i, j) sits in the bank whose parities are the base parities flipped by i, j
    c00   = dat[{par2_q[0],        par2_q[1]}];
    c01   = dat[{par2_q[0],        !par2_q[1]}];
    c10   = dat[{!par2_q[0],       par2_q[1]}];
    c11   = dat[{!par2_q[0],       !par2_q[1]}];
    upper = (rem2_q[0] <= rem2_q[1]);
    mid   = upper ? c01 : c10;
    if (upper) begin
      coef_r_d = $signed({1'b0, c11}) - $signed({1'b0, mid});
      coef_c_d = $signed({1'b0, mid}) - $signed({1'b0, c00});
    end else begin
      coef_r_d = $signed({1'b0, mid}) - $signed({1'b0, c00});
      coef_c_d = $signed({1'b0, c11}) - $signed({1'b0, mid});
    end
  end

  logic signed [D_W-1:0] coef_r3_q, coef_c3_q;
  logic [H_W-1:0]        lo3_q;
  logic signed [R_W-1:0] rem3_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      coef_r3_q <= coef_r_d;
      coef_c3_q <= coef_c_d;
      lo3_q     <= c00;
      rem3_q    <= rem2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // S4: scale the edge differences by the remainders
  // ---------------------------------------------------------------------------
  logic signed [M_W-1:0] prod_r4_q, prod_c4_q;
  logic [H_W-1:0]        lo4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      prod_r4_q <= M_W'(coef_r3_q * rem3_q[0]);
      prod_c4_q <= M_W'(coef_c3_q * rem3_q[1]);
      lo4_q     <= lo3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // S5: sum, divide toward zero, clamp to the height range
  // ---------------------------------------------------------------------------
  logic signed [NUM_W-1:0] num;
  logic [Q_W-1:0]          quo;
  logic [H_W-1:0]          h_d, h5_q;

  always_comb begin
    num = NUM_W'(prod_r4_q) + NUM_W'(prod_c4_q)
        + $signed({{(NUM_W-H_W-L){1'b0}}, lo4_q, {L{1'b0}}});
    quo = num[NUM_W-1:L];
    // a negative numerator truncates to zero or below, so it clamps to zero
    if (num[NUM_W-1]) begin
      h_d = '0;
    end else if (quo > Q_W'(HEIGHT_MAX)) begin
      h_d = H_W'(HEIGHT_MAX);
    end else begin
      h_d = quo[H_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      h5_q <= h_d;
    end
  end

  assign out_valid_o = v5_q;
  assign height_o    = h5_q;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for heightmap_triangle_interpolator_top: directed and random load and query beats,
// each query checked against a height predictor kept inside this bench.
// Depends on hti_pkg and the interpolator top level.
module tb;
  import hti_pkg::*;

  localparam int GD              = GRID_DIM_DEF;
  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 8;
  localparam int DRAIN_CYCLES    = 12;   // pipeline is five deep, leave some slack
  localparam int WATCHDOG_CYCLES = 500000;
  localparam int MAX_GAP         = 15;
  localparam int RANDOM_BEATS    = 1250;

  // DUT connections; every input is driven to a known value from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [0:0]            cfg_idx_i     = CFG_SQ_ROWS;
  logic [SQ_W-1:0]       cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic                  req_type_i    = REQ_LOAD;
  logic [BYTE_W-1:0]     grid_row_i    = '0;
  logic [BYTE_W-1:0]     grid_col_i    = '0;
  logic [BYTE_W-1:0]     height_byte_i = '0;
  logic signed [P_W-1:0] point_row_i   = '0;
  logic signed [P_W-1:0] point_col_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [H_W-1:0]        height_o;

  // Predictor state: its own copy of the grid and the map size
  logic [H_W-1:0]  terrain [GD][GD];
  logic [SQ_W-1:0] map_rows_sq = SQ_RESET;
  logic [SQ_W-1:0] map_cols_sq = SQ_RESET;
  logic [H_W-1:0]  heights_due [$];   // expected heights, oldest first

  // Idling switches for the sending and the receiving side
  logic        tx_idle = 1'b1;
  logic        rx_idle = 1'b1;
  int unsigned errors  = 0;

  heightmap_triangle_interpolator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .grid_row_i    (grid_row_i),
    .grid_col_i    (grid_col_i),
    .height_byte_i (height_byte_i),
    .point_row_i   (point_row_i),
    .point_col_i   (point_col_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .height_o      (height_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Height predictor
  // ---------------------------------------------------------------------------------------

  // Corner height at tile (tr, tc); anything off the padded area in use, or off the
  // storage itself, reads as zero. Bounds are applied after the padding is added.
  function automatic longint corner_height(int tr, int tc);
    longint pr, pc, rows_used, cols_used;
    pr        = longint'(tr) + PAD_TILES;
    pc        = longint'(tc) + PAD_TILES;
    rows_used = longint'(map_rows_sq) * TILES_PER_SQ + 2 * PAD_TILES + 1;
    cols_used = longint'(map_cols_sq) * TILES_PER_SQ + 2 * PAD_TILES + 1;
    if (pr < 0 || pc < 0 || pr >= rows_used || pc >= cols_used || pr >= GD || pc >= GD)
      return 0;
    return longint'(terrain[pr][pc]);
  endfunction

  // Interpolated height at a point: split each axis into tile and signed remainder
  // (truncating), pick the triangle by comparing remainders, divide truncating toward
  // zero, then clamp into the height range.
  function automatic logic [H_W-1:0] interp_height(logic signed [P_W-1:0] prow,
                                                   logic signed [P_W-1:0] pcol);
    int     tr, tc;
    longint rr, rc, lo, hi, mid, num, h;
    tr = int'(prow) / UNITS_PER_TILE;
    tc = int'(pcol) / UNITS_PER_TILE;
    rr = int'(prow) % UNITS_PER_TILE;
    rc = int'(pcol) % UNITS_PER_TILE;
    if (rr == 0 && rc == 0) begin
      h = corner_height(tr, tc);
    end else begin
      lo = corner_height(tr, tc);
      hi = corner_height(tr + 1, tc + 1);
      if (rr <= rc) begin
        mid = corner_height(tr, tc + 1);
        num = (hi - mid) * rr + (mid - lo) * rc;
      end else begin
        mid = corner_height(tr + 1, tc);
        num = (mid - lo) * rr + (hi - mid) * rc;
      end
      num = num + lo * UNITS_PER_TILE;
      h   = num / UNITS_PER_TILE;
    end
    if (h < 0)
      h = 0;
    if (h > HEIGHT_MAX)
      h = HEIGHT_MAX;
    return h[H_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------------------
  // Beat driving. Every task below starts and returns in the time step of a rising edge.
  // ---------------------------------------------------------------------------------------

  // Offer one beat, hold it until taken, then update the predictor in acceptance order.
  // Valid stays high on return so a back-to-back beat never drops it.
  task automatic send_beat(logic kind, logic [BYTE_W-1:0] row, logic [BYTE_W-1:0] col,
                           logic [BYTE_W-1:0] hb, logic signed [P_W-1:0] prow,
                           logic signed [P_W-1:0] pcol);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    grid_row_i    <= row;
    grid_col_i    <= col;
    height_byte_i <= hb;
    point_row_i   <= prow;
    point_col_i   <= pcol;
    do @(posedge clk_i); while (!in_ready_o);
    if (kind == REQ_LOAD)
      terrain[row][col] = {hb, {HS_LOG2{1'b0}}};
    else
      heights_due.push_back(interp_height(prow, pcol));
  endtask

  // Load beat; the point fields carry noise the block must ignore
  task automatic load_entry(int row, int col, int hb);
    send_beat(REQ_LOAD, BYTE_W'(row), BYTE_W'(col), BYTE_W'(hb),
              P_W'($urandom), P_W'($urandom));
  endtask

  // Query beat; the grid fields carry noise
  task automatic query_at(int prow, int pcol);
    send_beat(REQ_QUERY, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
              P_W'(prow), P_W'(pcol));
  endtask

  // Drop valid, wait for every expected height, then let any trailing load settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (heights_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both map size registers while the block is idle
  task automatic set_map(int rows, int cols);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SQ_ROWS;
    cfg_data_i <= SQ_W'(rows);
    @(posedge clk_i);
    map_rows_sq = SQ_W'(rows);
    cfg_idx_i  <= CFG_SQ_COLS;
    cfg_data_i <= SQ_W'(cols);
    @(posedge clk_i);
    map_cols_sq = SQ_W'(cols);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: random back-pressure and the check of every height beat
  // ---------------------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin : height_check
    logic [H_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (heights_due.size() == 0) begin
        $error("height: no beat expected, actual %0d", height_o);
        errors++;
      end else begin
        want = heights_due.pop_front();
        if (height_o !== want) begin
          $error("height: expected %0d, actual %0d", want, height_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Queries straight after reset: these wait out the grid clear and must all read zero
  task automatic test_cleared_grid();
    query_at(0, 0);
    query_at(5 * UNITS_PER_TILE + 17, 30);
    for (int i = 0; i < 4; i++)
      query_at(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
  endtask

  // Exact corners, both triangles, the diagonal, extrapolation into both clamps,
  // field extremes and points far outside the grid, all at the reset map size
  task automatic test_triangles();
    load_entry(0, 0, 255);          // lowest padded corner
    load_entry(255, 255, 255);      // stored beyond the area in use
    load_entry(16, 16, 255);        // tile (0,0) quad
    load_entry(16, 17, 0);
    load_entry(17, 16, 128);
    load_entry(17, 17, 8'h55);
    load_entry(15, 15, 8'hAA);      // far corner of tile (-1,-1)
    query_at(-16 * UNITS_PER_TILE, -16 * UNITS_PER_TILE);
    query_at(0, 0);
    query_at(10, 40);               // upper triangle
    query_at(40, 10);               // lower triangle
    query_at(32, 32);               // on the diagonal
    query_at(0, 63);
    query_at(63, 0);
    query_at(-1, -1);               // extrapolates above the top
    query_at(-1, -63);              // negative remainders, lower triangle
    query_at(-191, -129);           // extrapolates below zero
    query_at(32767, 32767);
    query_at(-32768, -32768);
    query_at(-32768, 32767);
    query_at(239 * UNITS_PER_TILE, 239 * UNITS_PER_TILE);
  endtask

  // Walk the map size through its extremes. At each size load the last row and column in
  // use, one entry just past the last row while it fits the grid, and probe every corner and
  // past entry loaded so far, so that entries stored outside the area come into view once it widens.
  task automatic test_map_sizes();
    int rows_set [8] = '{0, 1, 13, 15, 0, 15, 13, 6};
    int cols_set [8] = '{0, 13, 1, 15, 15, 0, 13, 6};
    int probe_r [$];
    int probe_c [$];
    int last_r, last_c, lr, lc;
    for (int k = 0; k < 8; k++) begin
      tx_idle = k[0];
      rx_idle = k[1];
      set_map(rows_set[k], cols_set[k]);
      last_r = rows_set[k] * TILES_PER_SQ + 2 * PAD_TILES;
      last_c = cols_set[k] * TILES_PER_SQ + 2 * PAD_TILES;
      lr     = (last_r > GD - 1) ? GD - 1 : last_r;
      lc     = (last_c > GD - 1) ? GD - 1 : last_c;
      load_entry(lr, lc, $urandom_range(0, 255));
      load_entry(lr - 1, lc, $urandom_range(0, 255));
      load_entry(lr, lc - 1, $urandom_range(0, 255));
      probe_r.push_back(lr);
      probe_c.push_back(lc);
      if (last_r < GD - 1) begin
        load_entry(last_r + 1, lc, $urandom_range(0, 255));
        probe_r.push_back(last_r + 1);
        probe_c.push_back(lc);
      end
      query_at((lr - PAD_TILES) * UNITS_PER_TILE, (lc - PAD_TILES) * UNITS_PER_TILE);
      query_at((lr - PAD_TILES - 1) * UNITS_PER_TILE + int'($urandom_range(1, 63)),
               (lc - PAD_TILES - 1) * UNITS_PER_TILE + int'($urandom_range(1, 63)));
      query_at((last_r - PAD_TILES + 1) * UNITS_PER_TILE,
               (last_c - PAD_TILES + 1) * UNITS_PER_TILE);
      foreach (probe_r[i])
        query_at((probe_r[i] - PAD_TILES) * UNITS_PER_TILE,
                 (probe_c[i] - PAD_TILES) * UNITS_PER_TILE);
    end
  endtask

  // Random traffic. Most beats land in a small window of the area in use so that loads
  // build real terrain under the queries; the rest is noise over the whole field range.
  task automatic test_random_traffic(int n_beats);
    int last_r, last_c, base_r, base_c, pick;
    for (int i = 0; i < n_beats; i++) begin
      if (i % 250 == 0) begin
        set_map($urandom_range(0, 15), $urandom_range(0, 15));
        last_r = int'(map_rows_sq) * TILES_PER_SQ + 2 * PAD_TILES;
        last_c = int'(map_cols_sq) * TILES_PER_SQ + 2 * PAD_TILES;
        if (last_r > GD - 1)
          last_r = GD - 1;
        if (last_c > GD - 1)
          last_c = GD - 1;
      end
      if (i % 50 == 0) begin
        base_r = $urandom_range(0, last_r - 6);
        base_c = $urandom_range(0, last_c - 6);
      end
      // alternate stretches with and without idling on either side
      if (i % 60 == 0)
        {tx_idle, rx_idle} = 2'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35)
        load_entry(base_r + int'($urandom_range(0, 6)), base_c + int'($urandom_range(0, 6)),
                   $urandom_range(0, 255));
      else if (pick < 87)
        query_at((base_r - PAD_TILES) * UNITS_PER_TILE + int'($urandom_range(0, 384)) - 32,
                 (base_c - PAD_TILES) * UNITS_PER_TILE + int'($urandom_range(0, 384)) - 32);
      else if (pick < 93)
        load_entry($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      else
        query_at(int'($urandom_range(0, 65535)) - 32768,
                 int'($urandom_range(0, 65535)) - 32768);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, drain and report
  // ---------------------------------------------------------------------------------------

  initial begin : run_tests
    foreach (terrain[r, c])
      terrain[r][c] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cleared_grid();
    test_triangles();
    test_map_sizes();
    test_random_traffic(RANDOM_BEATS);
    wait_drained();
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Hard stop well beyond the slowest legal run, grid clear included
  initial begin : watchdog
    #(WATCHDOG_CYCLES * 2 * CLK_HALF);
    $display("== FAIL ==");
    $finish;
  end

endmodule
